### rtl/hsfd_pkg.sv
// Shared types, constants and the CRC-8 function of the humidity sensor frame decoder.
// Used by every module of the block; depends on nothing.
package hsfd_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Byte positions within one six-byte frame.
   localparam logic [2:0] POS_T_MSB = 3'd0;
   localparam logic [2:0] POS_T_LSB = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_MSB = 3'd3;
   localparam logic [2:0] POS_H_LSB = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
   localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;
   localparam logic [1:0] STATUS_DISABLED = 2'd3;

   // Scaling constants: the full-scale raw word is 65535.
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;
   localparam logic [16:0] RAW_FULL    = 17'd65535;

   // One completed frame, handed from the front end to the scaling back end.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] temperature_raw;
      logic [15:0] humidity_raw;
   } frame_job_type;

   // One byte of CRC-8, MSB first.
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/hsfd_front.sv
// Front end: tracks the byte position, runs the CRC-8 and collects the raw words.
// Emits one frame job per completed frame. Depends on hsfd_pkg.
module hsfd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_accept,
   input  logic [7:0]             data_byte,
   input  logic                   frame_start,
   input  logic                   sensor_enabled,
   output logic                   job_push,
   output hsfd_pkg::frame_job_type job_data
);
   import hsfd_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] t_raw_ff, t_raw_in;
   logic [15:0] h_raw_ff, h_raw_in;
   logic        t_good_ff, t_good_in;

   logic [2:0]  pos_eff;
   logic [7:0]  crc_eff;
   logic [7:0]  crc_next;
   logic        h_good;

   always_comb begin
      // A frame start, or an out-of-range position, restarts the frame.
      if (frame_start || pos_ff > POS_H_CRC) begin
         pos_eff = POS_T_MSB;
         crc_eff = CRC_INIT;
      end else begin
         pos_eff = pos_ff;
         crc_eff = crc_ff;
      end
      crc_next = crc8_feed(crc_eff, data_byte);
      h_good   = (crc_eff == data_byte);

      pos_in    = pos_ff;
      crc_in    = crc_ff;
      t_raw_in  = t_raw_ff;
      h_raw_in  = h_raw_ff;
      t_good_in = t_good_ff;
      job_push  = 1'b0;

      if (byte_accept) begin
         pos_in = pos_eff + 3'd1;
         case (pos_eff)
            POS_T_MSB: begin
               t_raw_in = {data_byte, t_raw_ff[7:0]};
               crc_in   = crc_next;
            end
            POS_T_LSB: begin
               t_raw_in = {t_raw_ff[15:8], data_byte};
               crc_in   = crc_next;
            end
            POS_T_CRC: begin
               t_good_in = (crc_eff == data_byte);
               crc_in    = CRC_INIT;
            end
            POS_H_MSB: begin
               h_raw_in = {data_byte, h_raw_ff[7:0]};
               crc_in   = crc_next;
            end
            POS_H_LSB: begin
               h_raw_in = {h_raw_ff[15:8], data_byte};
               crc_in   = crc_next;
            end
            default: begin
               crc_in   = CRC_INIT;
               pos_in   = POS_T_MSB;
               job_push = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      job_data.temperature_raw = t_raw_ff;
      job_data.humidity_raw    = h_raw_ff;
      if (!sensor_enabled) begin
         job_data.status = STATUS_DISABLED;
      end else if (!t_good_ff) begin
         job_data.status = STATUS_TEMP_CRC;
      end else if (!h_good) begin
         job_data.status = STATUS_HUM_CRC;
      end else begin
         job_data.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_T_MSB;
         crc_ff    <= CRC_INIT;
         t_raw_ff  <= '0;
         h_raw_ff  <= '0;
         t_good_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         t_raw_ff  <= t_raw_in;
         h_raw_ff  <= h_raw_in;
         t_good_ff <= t_good_in;
      end
   end

endmodule

### rtl/hsfd_queue.sv
// Small frame-job queue between the front end and the scaling back end.
// Depends on hsfd_pkg for the job type.
module hsfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hsfd_pkg::frame_job_type push_data,
   input  logic                   pop,
   output logic                   not_empty,
   output logic                   full,
   output hsfd_pkg::frame_job_type head_data
);
   import hsfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   frame_job_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == FULL_CNT);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/hsfd_back.sv
// Back end: scales the raw words to hundredths and drives the result register.
// Two stages: constant multiply, then divide-by-65535 correction. Depends on hsfd_pkg.
module hsfd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  hsfd_pkg::frame_job_type job_data,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic                   rsp_reading_valid,
   output logic signed [14:0]     rsp_temperature_centi,
   output logic [13:0]            rsp_humidity_centi
);
   import hsfd_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_status_ff;
   logic [30:0] t_prod_ff;
   logic [29:0] h_prod_ff;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff;
   logic        out_ok_ff;
   logic [14:0] out_temp_ff;
   logic [13:0] out_hum_ff;

   logic        out_move, s1_move;
   logic [14:0] t_q0, t_q;
   logic [16:0] t_r0;
   logic [13:0] h_q0, h_q;
   logic [16:0] h_r0;
   logic        s1_ok;

   // The output register takes a new value when it is empty or being drained.
   assign out_move = !out_valid_ff || !rsp_stall;
   assign s1_move  = !s1_valid_ff || out_move;
   assign job_pop  = job_valid && s1_move;

   assign s1_valid_in  = s1_move ? job_valid : s1_valid_ff;
   assign out_valid_in = out_move ? s1_valid_ff : out_valid_ff;

   // floor(p / 65535): p >> 16 is low by at most one, the remainder stays below 2 * 65535.
   always_comb begin
      t_q0  = t_prod_ff[30:16];
      t_r0  = {1'b0, t_prod_ff[15:0]} + {2'b00, t_q0};
      t_q   = t_q0 + {14'd0, (t_r0 >= RAW_FULL)};
      h_q0  = h_prod_ff[29:16];
      h_r0  = {1'b0, h_prod_ff[15:0]} + {3'b000, h_q0};
      h_q   = h_q0 + {13'd0, (h_r0 >= RAW_FULL)};
      s1_ok = (s1_status_ff == STATUS_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_status_ff <= job_data.status;
         t_prod_ff    <= {15'd0, job_data.temperature_raw} * {16'd0, TEMP_SPAN};
         h_prod_ff    <= {14'd0, job_data.humidity_raw} * {16'd0, HUM_SPAN};
      end
      if (out_move) begin
         out_status_ff <= s1_status_ff;
         out_ok_ff     <= s1_ok;
         out_temp_ff   <= s1_ok ? (t_q - TEMP_OFFSET) : '0;
         out_hum_ff    <= s1_ok ? h_q : '0;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_reading_valid     = out_ok_ff;
   assign rsp_temperature_centi = signed'(out_temp_ff);
   assign rsp_humidity_centi    = out_hum_ff;

endmodule

### rtl/humidity_sensor_frame_decoder_top.sv
// Top level of the temperature and humidity frame decoder.
// Instantiates hsfd_front, hsfd_queue and hsfd_back; depends on hsfd_pkg.
//
// The req_ channel carries one received sensor byte per transfer, in the order
// temperature MSB, temperature LSB, temperature CRC, humidity MSB, humidity LSB,
// humidity CRC. Raising req_frame_start marks a byte as the first of a frame and
// drops any partial frame in progress. The rsp_ channel carries one result per
// completed six-byte frame: status, a valid flag and the scaled readings.
// A byte is taken in every cycle that req_stall is low; the CRC-8 of a byte is
// computed in the same cycle it is accepted. The result of a frame reaches rsp_valid
// through the queue entry, the constant multipliers, and the divide-by-65535
// correction and output register.
// Completed frames wait in a queue of QUEUE_DEPTH entries, so the receiver may
// stall rsp_ for a while without slowing the byte side. Only when that queue is
// full does req_stall rise, holding off further bytes until a result drains.
// The csr_ port writes the sensor enable bit; it is sampled with the sixth byte.
// Synchronous reset restarts the frame position and CRC, empties the queue and
// the pipeline, and sets the sensor enable bit.
module humidity_sensor_frame_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_reading_valid,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);
   import hsfd_pkg::*;

   // Sensor enable register; resets to enabled.
   logic sensor_enabled_ff, sensor_enabled_in;

   logic          byte_accept;
   logic          job_push;
   frame_job_type push_job;
   logic          job_valid;
   logic          queue_full;
   logic          job_pop;
   frame_job_type head_job;

   assign sensor_enabled_in = csr_write_enable ? csr_write_data : sensor_enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_enabled_ff <= 1'b1;
      end else begin
         sensor_enabled_ff <= sensor_enabled_in;
      end
   end

   // Hold off bytes while the queue has no room for a completed frame.
   assign req_stall   = queue_full;
   assign byte_accept = req_valid && !req_stall;

   hsfd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .byte_accept    (byte_accept),
      .data_byte      (req_data_byte),
      .frame_start    (req_frame_start),
      .sensor_enabled (sensor_enabled_ff),
      .job_push       (job_push),
      .job_data       (push_job)
   );

   hsfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .pop       (job_pop),
      .not_empty (job_valid),
      .full      (queue_full),
      .head_data (head_job)
   );

   hsfd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .job_valid             (job_valid),
      .job_data              (head_job),
      .job_pop               (job_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_reading_valid     (rsp_reading_valid),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi)
   );

endmodule

### verif/tb_top.sv
// Self-checking testbench for humidity_sensor_frame_decoder_top: sends sensor bytes and checks
// each frame result against a built-in predictor of the frame decoder.
// Depends on hsfd_pkg and the decoder RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hsfd_pkg::*;

   // Cycles with no transfer on either channel before the run is declared hung.
   // The longest quiet stretch is the deliberate receiver hold-off.
   localparam int QUIET_LIMIT  = 3000;
   // Cycles allowed after the last expected result before a register write or the end.
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 400;

   // One decoded frame as it appears on the result channel.
   typedef struct {
      logic [1:0]         status;
      logic               ok;
      logic signed [14:0] temp;
      logic [13:0]        hum;
   } reading_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_data_byte;
   logic req_frame_start;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_status;
   logic rsp_reading_valid;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0] rsp_humidity_centi;
   logic csr_write_enable;
   logic csr_write_data;

   humidity_sensor_frame_decoder_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data_byte         (req_data_byte),
      .req_frame_start       (req_frame_start),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_reading_valid     (rsp_reading_valid),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   always #5 clock = ~clock;

   // Predictor state: our own copy of the frame position, CRC, raw words and enable bit.
   logic [2:0]  frame_pos;
   logic [7:0]  crc_acc;
   logic [15:0] t_word;
   logic [15:0] h_word;
   logic        t_crc_ok;
   logic        enable_copy;

   // Readings predicted but not yet seen on the result channel, oldest first.
   reading_type pending_readings[$];

   int mismatches = 0;
   int bytes_sent = 0;

   // Sender bookkeeping. The idle gap before the next byte is drawn as soon as a byte
   // transfers, so that valid is either dropped right there or kept high for a
   // back-to-back transfer; it is never lowered and raised in the same time step.
   bit offering = 1'b0;
   int pending_gap = 0;
   int sender_max_gap = 12;
   int rsp_max_stall = 12;
   int long_hold = 0;

   // CRC-8, polynomial 0x31, fed one data bit at a time from the MSB.
   function automatic logic [7:0] crc8_bitwise(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   function automatic logic [7:0] word_crc(input logic [15:0] w);
      return crc8_bitwise(crc8_bitwise(CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   task automatic reset_model();
      frame_pos = POS_T_MSB;
      crc_acc = CRC_INIT;
      t_word = '0;
      h_word = '0;
      t_crc_ok = 1'b0;
      enable_copy = 1'b1;
   endtask

   // Advances the predictor by one accepted byte and queues the reading that a
   // sixth byte produces.
   task automatic predict_byte(input logic [7:0] b, input logic start);
      reading_type r;
      logic h_match;
      longint t_val;
      longint h_val;
      if (start) begin
         frame_pos = POS_T_MSB;
         crc_acc = CRC_INIT;
      end
      // Positions six and seven cannot occur, but would restart the frame.
      if (frame_pos > POS_H_CRC) begin
         frame_pos = POS_T_MSB;
         crc_acc = CRC_INIT;
      end
      case (frame_pos)
         POS_T_MSB: begin
            t_word[15:8] = b;
            crc_acc = crc8_bitwise(crc_acc, b);
         end
         POS_T_LSB: begin
            t_word[7:0] = b;
            crc_acc = crc8_bitwise(crc_acc, b);
         end
         POS_T_CRC: begin
            t_crc_ok = (crc_acc == b);
            crc_acc = CRC_INIT;
         end
         POS_H_MSB: begin
            h_word[15:8] = b;
            crc_acc = crc8_bitwise(crc_acc, b);
         end
         POS_H_LSB: begin
            h_word[7:0] = b;
            crc_acc = crc8_bitwise(crc_acc, b);
         end
         default: begin
            h_match = (crc_acc == b);
            crc_acc = CRC_INIT;
            r.status = STATUS_OK;
            r.ok = 1'b0;
            r.temp = '0;
            r.hum = '0;
            // Disabled wins over both CRC checks; a bad temperature CRC wins over humidity.
            if (!enable_copy) begin
               r.status = STATUS_DISABLED;
            end else if (!t_crc_ok) begin
               r.status = STATUS_TEMP_CRC;
            end else if (!h_match) begin
               r.status = STATUS_HUM_CRC;
            end else begin
               t_val = -64'sd4500 + (64'sd17500 * longint'({48'd0, t_word})) / 64'sd65535;
               h_val = (64'sd10000 * longint'({48'd0, h_word})) / 64'sd65535;
               r.ok = 1'b1;
               r.temp = t_val[14:0];
               r.hum = h_val[13:0];
            end
            pending_readings.push_back(r);
         end
      endcase
      frame_pos = (frame_pos >= POS_H_CRC) ? POS_T_MSB : frame_pos + 3'd1;
   endtask

   // Offers one byte and returns in the time step of its transfer.
   task automatic send_byte(input logic [7:0] b, input logic start);
      if (!offering) begin
         repeat (pending_gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_frame_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(b, start);
      bytes_sent++;
      pending_gap = $urandom_range(0, sender_max_gap);
      offering = (pending_gap == 0);
      if (!offering) begin
         req_valid <= 1'b0;
      end
   endtask

   // Takes the sender off the channel when it was left offering for a back-to-back byte.
   task automatic sender_idle();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                             input logic [7:0] t_flip, input logic [7:0] h_flip,
                             input logic lead_start);
      send_byte(t_raw[15:8], lead_start);
      send_byte(t_raw[7:0], 1'b0);
      send_byte(word_crc(t_raw) ^ t_flip, 1'b0);
      send_byte(h_raw[15:8], 1'b0);
      send_byte(h_raw[7:0], 1'b0);
      send_byte(word_crc(h_raw) ^ h_flip, 1'b0);
   endtask

   task automatic wait_drained();
      sender_idle();
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the decoder idle and every reading collected.
   task automatic set_enable(input logic value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      enable_copy = value;
   endtask

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [7:0] pick_crc_flip();
      return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
   endfunction

   task automatic note_mismatch();
      mismatches++;
   endtask

   // Directed frames with the enable bit at its reset value: scaling extremes, each CRC
   // failure, both CRCs bad, a missing frame start and a partial frame that a new start drops.
   task automatic test_directed_frames();
      send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00, 1'b1);
      // No frame start: the position simply wrapped, so this is the next frame.
      send_frame(16'hFFFF, 16'h0000, 8'hFF, 8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_frame(16'h8000, 16'h0001, 8'h00, 8'h01, 1'b1);
      send_frame(16'h6666, 16'h9999, 8'h80, 8'h80, 1'b1);
   endtask

   // Disabled frames report their own status whatever their CRCs, then enable is restored.
   task automatic test_enable_register();
      set_enable(1'b0);
      send_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 1'b1);
      send_frame(16'hFFFF, 16'h0000, 8'h10, 8'h20, 1'b1);
      set_enable(1'b1);
      send_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 1'b1);
   endtask

   // Mostly well-formed frames with random content, some without a frame start,
   // the rest random noise bytes with random frame starts.
   task automatic random_burst(input int count);
      int target;
      int pick;
      int noise_len;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         // Change the idling style now and then, including stretches with none at all.
         if ($urandom_range(0, 7) == 0) begin
            sender_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 12;
            rsp_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 12;
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_frame(pick_raw(), pick_raw(), pick_crc_flip(), pick_crc_flip(), 1'b1);
         end else if (pick == 7) begin
            // Leave out the frame start only where the position is already at the frame head.
            send_frame(pick_raw(), pick_raw(), pick_crc_flip(), pick_crc_flip(),
                       (frame_pos != POS_T_MSB) || ($urandom_range(0, 1) == 1));
         end else begin
            noise_len = $urandom_range(1, 7);
            repeat (noise_len) send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   task automatic test_random_traffic();
      random_burst(360);
      set_enable(1'b0);
      random_burst(90);
      set_enable(1'b1);
      random_burst(160);
      sender_max_gap = 12;
      rsp_max_stall = 12;
   endtask

   // The receiver holds off for a long stretch while bytes keep coming, so the result
   // queue fills and the decoder has to stall its byte input.
   task automatic test_result_backpressure();
      wait_drained();
      long_hold = LONG_HOLD;
      sender_max_gap = 0;
      rsp_max_stall = 0;
      repeat (16) send_frame(pick_raw(), pick_raw(), 8'h00, 8'h00, 1'b1);
      sender_max_gap = 12;
      rsp_max_stall = 12;
   endtask

   task automatic finish_run();
      wait_drained();
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   endtask

   // Receiver stall pattern. A fresh stall length is drawn after every result transfer;
   // a requested long hold-off replaces one draw.
   initial begin : rsp_stall_driver
      int n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
         end else begin
            n = $urandom_range(0, rsp_max_stall);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // Every result transfer is compared field by field with the oldest predicted reading.
   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            note_mismatch();
            if (mismatches <= 10) begin
               $display("%0t: unexpected reading: status %0d valid %0d temp %0d hum %0d",
                        $realtime, rsp_status, rsp_reading_valid,
                        rsp_temperature_centi, rsp_humidity_centi);
            end
         end else begin
            want = pending_readings.pop_front();
            if (rsp_status !== want.status || rsp_reading_valid !== want.ok ||
                rsp_temperature_centi !== want.temp || rsp_humidity_centi !== want.hum) begin
               note_mismatch();
               if (mismatches <= 10) begin
                  $display({"%0t: reading mismatch: expected status %0d valid %0d ",
                            "temp %0d hum %0d, got status %0d valid %0d temp %0d hum %0d"},
                           $realtime, want.status, want.ok, want.temp, want.hum,
                           rsp_status, rsp_reading_valid, rsp_temperature_centi,
                           rsp_humidity_centi);
               end
            end
         end
      end
   end

   // Watchdog: too long without any transfer means the decoder has hung.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_frame_start <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= 1'b0;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_enable_register();
      test_random_traffic();
      test_result_backpressure();
      finish_run();
   end

endmodule
